// ===== rtl/core/mrrt_pkg.sv =====
// Package with payload types and sequencer codes for the Miller-Rabin round test.
package mrrt_pkg;

   typedef struct packed {
      logic [31:0] candidate;
      logic [31:0] random_word;
   } req_word_type;

   typedef struct packed {
      logic        verdict;
      logic        settled;
      logic [31:0] witness_base;
   } rsp_word_type;

   localparam logic [1:0] OP_MOD = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } unit_ctl_type;

endpackage

// ===== rtl/core/miller_rabin_round_test.sv =====
// Top level of the Miller-Rabin round test: sequencer around one shared modular unit.
// Usage: a word on the req_ channel carries a candidate and a random word; the
// block answers with exactly one word on the rsp_ channel holding the verdict,
// whether the small or even check settled it, and the witness base used.
// Only one word is in work at a time: req_stall is high from acceptance until
// the result has been taken.
// Settled candidates pass from S_IDLE through S_OUT to the result register. A full round
// takes one base reduction, then per exponent bit one or two modular products,
// then up to s-1 squarings. Each reduction or product runs bit-serially through
// the unit, which is 33 bits wide for candidates of up to 32 bits.
// The result register holds the word while rsp_stall is high; the block does
// not take a new word until the result has left.
// Reset is synchronous and clears the sequencer and the result valid.
module miller_rabin_round_test #(
   parameter int N_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mrrt_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mrrt_pkg::rsp_word_type rsp_data
);
   import mrrt_pkg::*;

   localparam int W = ((N_BITS > 32) ? N_BITS : 32) + 1;
   localparam int EW = $clog2(N_BITS + 1);
   localparam logic [31:0] CAND_MASK =
      (N_BITS >= 32) ? 32'hFFFFFFFF : 32'((64'd1 << N_BITS) - 64'd1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SPLIT = 4'd1;
   localparam logic [3:0] S_BASE = 4'd2;
   localparam logic [3:0] S_BWAIT = 4'd3;
   localparam logic [3:0] S_EXP = 4'd4;
   localparam logic [3:0] S_MWAIT = 4'd5;
   localparam logic [3:0] S_SQ = 4'd6;
   localparam logic [3:0] S_SWAIT = 4'd7;
   localparam logic [3:0] S_CHECK = 4'd8;
   localparam logic [3:0] S_LOOP = 4'd9;
   localparam logic [3:0] S_LWAIT = 4'd10;
   localparam logic [3:0] S_OUT = 4'd11;

   logic [3:0]   state_ff, state_in;
   logic [W-1:0] n_ff, n_in;
   logic [W-1:0] d_ff, d_in;
   logic [EW-1:0] s_ff, s_in;
   logic [W-1:0] x_ff, x_in;
   logic [W-1:0] b_ff, b_in;
   logic [31:0]  w_ff, w_in;
   logic [31:0]  base_ff, base_in;
   logic         rv_ff, rv_in;
   rsp_word_type rd_ff, rd_in;
   unit_ctl_type ctl;
   logic [W-1:0] ua, ub, um, ures;
   logic         udone;
   logic [W-1:0] cand;
   logic [W-1:0] nm1;

   mrrt_modunit #(.W(W)) u_unit (
      .clock(clock), .reset(reset), .ctl(ctl), .a(ua), .b(ub), .m(um),
      .done(udone), .result(ures)
   );

   assign cand = W'(req_data.candidate & CAND_MASK);
   assign nm1 = n_ff - 1'b1;
   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data = rd_ff;

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; d_in = d_ff; s_in = s_ff; x_in = x_ff; b_in = b_ff;
      w_in = w_ff; base_in = base_ff; rv_in = rv_ff; rd_in = rd_ff;
      ctl.start = 1'b0; ctl.op = OP_MUL;
      ua = b_ff; ub = b_ff; um = n_ff;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !rv_ff) begin
               n_in = cand;
               w_in = req_data.random_word;
               if (cand < W'(2) || (cand > W'(3) && !cand[0])) begin
                  rd_in = '{verdict: 1'b0, settled: 1'b1, witness_base: '0};
                  state_in = S_OUT;
               end else if (cand <= W'(3)) begin
                  rd_in = '{verdict: 1'b1, settled: 1'b1, witness_base: '0};
                  state_in = S_OUT;
               end else begin
                  d_in = cand - 1'b1;
                  s_in = '0;
                  state_in = S_SPLIT;
               end
            end
         end
         S_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               s_in = s_ff + 1'b1;
            end else begin
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            ctl.start = 1'b1; ctl.op = OP_MOD;
            ub = W'(w_ff); um = n_ff - W'(3);
            state_in = S_BWAIT;
         end
         S_BWAIT: begin
            um = n_ff - W'(3);
            if (udone) begin
               b_in = ures + W'(2);
               base_in = 32'(ures + W'(2));
               x_in = W'(1);
               state_in = S_EXP;
            end
         end
         S_EXP: begin
            if (d_ff == '0) begin
               state_in = S_CHECK;
            end else if (d_ff[0]) begin
               ctl.start = 1'b1; ua = x_ff; ub = b_ff;
               state_in = S_MWAIT;
            end else begin
               state_in = S_SQ;
            end
         end
         S_MWAIT: begin
            if (udone) begin
               x_in = ures;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            ctl.start = 1'b1;
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (udone) begin
               b_in = ures;
               d_in = d_ff >> 1;
               state_in = S_EXP;
            end
         end
         S_CHECK: begin
            if (x_ff == W'(1) || x_ff == nm1) begin
               rd_in = '{verdict: 1'b1, settled: 1'b0, witness_base: base_ff};
               state_in = S_OUT;
            end else if (s_ff <= EW'(1)) begin
               rd_in = '{verdict: 1'b0, settled: 1'b0, witness_base: base_ff};
               state_in = S_OUT;
            end else begin
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            ctl.start = 1'b1; ua = x_ff; ub = x_ff;
            state_in = S_LWAIT;
         end
         S_LWAIT: begin
            if (udone) begin
               x_in = ures;
               if (ures == nm1) begin
                  rd_in = '{verdict: 1'b1, settled: 1'b0, witness_base: base_ff};
                  state_in = S_OUT;
               end else if (s_ff <= EW'(2)) begin
                  rd_in = '{verdict: 1'b0, settled: 1'b0, witness_base: base_ff};
                  state_in = S_OUT;
               end else begin
                  s_in = s_ff - 1'b1;
                  state_in = S_LOOP;
               end
            end
         end
         S_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
      n_ff <= n_in; d_ff <= d_in; s_ff <= s_in; x_ff <= x_in; b_ff <= b_in;
      w_ff <= w_in; base_ff <= base_in; rd_ff <= rd_in;
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> (rv_ff && $stable(rd_ff)))
      else $error("result changed while stalled");
   a_settled_base: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rd_ff.settled) |-> (rd_ff.witness_base == '0))
      else $error("settled result with a base");

endmodule

// ===== rtl/core/mrrt_modunit.sv =====
// Shared bit-serial unit: modular reduction and modular multiplication, one bit a cycle.
module mrrt_modunit #(
   parameter int W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mrrt_pkg::unit_ctl_type ctl,
   input  logic [W-1:0]          a,
   input  logic [W-1:0]          b,
   input  logic [W-1:0]          m,
   output logic                  done,
   output logic [W-1:0]          result
);
   import mrrt_pkg::*;

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic [1:0]    op_ff, op_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  sh_ff, sh_in;
   logic [W-1:0]  mul_ff, mul_in;
   logic [W-1:0]  m_ff, m_in;
   logic [W:0]    dbl;
   logic [W:0]    sum;
   logic [W:0]    t0, t1;

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      mul_in  = mul_ff;
      m_in    = m_ff;
      done    = 1'b0;
      dbl = {acc_ff, 1'b0};
      if (op_ff == OP_MOD) begin
         dbl = {acc_ff, sh_ff[W-1]};
      end
      t0 = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum = t0 + {1'b0, mul_ff};
      t1 = t0;
      if (op_ff == OP_MUL && sh_ff[W-1]) begin
         t1 = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
      end
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = CW'(W);
         acc_in  = '0;
         sh_in   = b;
         mul_in  = a;
         m_in    = m;
      end else if (busy_ff) begin
         acc_in = t1[W-1:0];
         sh_in  = {sh_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   assign result = t1[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      mul_ff <= mul_in;
      m_ff   <= m_in;
   end

endmodule
